// ===== src/grs_pkg.sv =====
`timescale 1ns / 1ps

package grs_pkg;

	// Width of an element count inside one command. It covers groups of up to
	// 511 elements.
	localparam int unsigned GRS_CNT_W = 9;

	// One burst for the back end: which bank holds it, how many elements,
	// whether to read them newest first, and whether the burst closes the list.
	typedef struct packed {
		logic                 bank;
		logic [GRS_CNT_W-1:0] count;
		logic                 reverse;
		logic                 last;
	} grs_cmd_t;

	// The back end hands a bank back to the front once its last read is issued.
	typedef struct packed {
		logic valid;
		logic bank;
	} grs_release_t;

endpackage

// ===== src/grs_store.sv =====
`timescale 1ns / 1ps

module grs_store #(
	parameter int unsigned AW = 4
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW:0]   wr_addr,
	input  logic [31:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW:0]   rd_addr,
	output logic [31:0]   rd_data
);

	localparam int unsigned DEPTH = 2 * (1 << AW);

	// Two banks of group storage, selected by the top address bit.
	logic [31:0] mem [DEPTH];
	logic [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/grs_cmd_queue.sv =====
`timescale 1ns / 1ps

module grs_cmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  grs_pkg::grs_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output grs_pkg::grs_cmd_t head,
	output logic              empty
);

	import grs_pkg::*;

	grs_cmd_t   slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// The front must never push into a full queue, and the back must never
	// take a command that is not there.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("command queue underflow");

endmodule

// ===== src/grs_front.sv =====
`timescale 1ns / 1ps

module grs_front #(
	parameter int unsigned MAX_GROUP = 16,
	parameter int unsigned AW        = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  group_size_we,
	input  logic [4:0]            group_size,
	input  logic                  elem_valid,
	output logic                  elem_stall,
	input  logic [31:0]           value,
	input  logic                  list_end,
	output logic                  wr_en,
	output logic [AW:0]           wr_addr,
	output logic [31:0]           wr_data,
	output logic                  cmd_push,
	output grs_pkg::grs_cmd_t     cmd,
	input  logic                  q_full,
	input  grs_pkg::grs_release_t rel
);

	import grs_pkg::*;

	localparam int unsigned FW = $clog2(MAX_GROUP + 1);
	localparam int unsigned KW = (FW > 5) ? FW : 5;

	logic [4:0]    gsize_q;
	logic [FW-1:0] fill_q;
	logic          wbank_q;
	logic [1:0]    busy_q;
	logic [1:0]    busy_nxt;

	logic [KW-1:0] gs_ext;
	logic [KW-1:0] k_eff;
	logic          accept;
	logic          room;
	logic [FW-1:0] fill_new;
	logic          full_grp;

	// Clamp the configured size to the range the storage supports.
	always_comb begin
		gs_ext = KW'(gsize_q);
		if (gs_ext == '0) begin
			k_eff = KW'(1);
		end else if (gs_ext > KW'(MAX_GROUP)) begin
			k_eff = KW'(MAX_GROUP);
		end else begin
			k_eff = gs_ext;
		end
	end

	// The write bank must be free: the back end may still be reading it.
	assign elem_stall = busy_q[wbank_q] | q_full;
	assign accept     = elem_valid & ~elem_stall;

	assign room     = (fill_q < FW'(MAX_GROUP));
	assign fill_new = room ? (fill_q + FW'(1)) : fill_q;
	assign full_grp = (KW'(fill_new) >= k_eff);

	assign wr_en   = accept & room;
	assign wr_addr = {wbank_q, fill_q[AW-1:0]};
	assign wr_data = value;

	assign cmd_push    = accept & (full_grp | list_end);
	assign cmd.bank    = wbank_q;
	assign cmd.count   = GRS_CNT_W'(fill_new);
	assign cmd.reverse = full_grp;
	assign cmd.last    = list_end;

	always_comb begin
		busy_nxt = busy_q;
		if (rel.valid) begin
			busy_nxt[rel.bank] = 1'b0;
		end
		if (cmd_push) begin
			busy_nxt[wbank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gsize_q <= 5'd1;
			fill_q  <= '0;
			wbank_q <= 1'b0;
			busy_q  <= 2'b00;
		end else begin
			if (group_size_we) begin
				gsize_q <= group_size;
			end
			if (accept) begin
				if (cmd_push) begin
					fill_q  <= '0;
					wbank_q <= ~wbank_q;
				end else begin
					fill_q <= fill_new;
				end
			end
			busy_q <= busy_nxt;
		end
	end

	// The back end only hands back a bank that was handed to it.
	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rel.valid |-> busy_q[rel.bank]) else $error("release of a free bank");

	// A group always closes before the bank runs out of entries.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < FW'(MAX_GROUP)) else $error("group fill past bank depth");

endmodule

// ===== src/grs_back.sv =====
`timescale 1ns / 1ps

module grs_back #(
	parameter int unsigned AW = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  grs_pkg::grs_cmd_t     q_head,
	output logic                  q_pop,
	output logic                  rd_en,
	output logic [AW:0]           rd_addr,
	input  logic [31:0]           rd_data,
	output grs_pkg::grs_release_t rel,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [31:0]           res_value,
	output logic                  res_run_end,
	output logic                  res_list_done
);

	import grs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} back_state_t;

	typedef struct packed {
		logic [31:0] value;
		logic        run_end;
		logic        list_done;
	} grs_res_t;

	back_state_t          state_q;
	grs_cmd_t             cur_q;
	logic [GRS_CNT_W-1:0] idx_q;
	logic                 valid_s1;
	logic                 run_end_s1;
	logic                 list_done_s1;

	grs_res_t             res_q [4];
	logic [1:0]           wp_q;
	logic [1:0]           rp_q;
	logic [2:0]           occ_q;

	logic                 credit_ok;
	logic                 issue;
	logic                 last_rd;
	logic [GRS_CNT_W-1:0] rd_idx;
	logic                 res_pop;

	// A read is issued only when the result buffer is sure to have room for it.
	assign credit_ok = ((occ_q + {2'b00, valid_s1}) < 3'd4);
	assign issue     = (state_q == ST_RUN) && credit_ok;
	assign last_rd   = (idx_q == (cur_q.count - GRS_CNT_W'(1)));
	assign rd_idx    = cur_q.reverse ? (cur_q.count - GRS_CNT_W'(1) - idx_q) : idx_q;

	assign rd_en   = issue;
	assign rd_addr = {cur_q.bank, rd_idx[AW-1:0]};
	assign q_pop   = (state_q == ST_IDLE) && !q_empty;

	assign rel.valid = issue & last_rd;
	assign rel.bank  = cur_q.bank;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		run_end_s1   <= last_rd;
		list_done_s1 <= last_rd & cur_q.last;
		if (valid_s1) begin
			res_q[wp_q] <= '{value: rd_data, run_end: run_end_s1, list_done: list_done_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			wp_q     <= 2'd0;
			rp_q     <= 2'd0;
			occ_q    <= 3'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						idx_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue) begin
						if (last_rd) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + GRS_CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			valid_s1 <= issue;
			if (valid_s1) begin
				wp_q <= wp_q + 2'd1;
			end
			if (res_pop) begin
				rp_q <= rp_q + 2'd1;
			end
			occ_q <= occ_q + 3'(valid_s1) - 3'(res_pop);
		end
	end

	assign res_valid     = (occ_q != 3'd0);
	assign res_pop       = res_valid & ~res_stall;
	assign res_value     = res_q[rp_q].value;
	assign res_run_end   = res_q[rp_q].run_end;
	assign res_list_done = res_q[rp_q].list_done;

	// Reads in flight plus buffered results never exceed the buffer depth.
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q + {2'b00, valid_s1}) <= 3'd4) else $error("result buffer overrun");

endmodule

// ===== src/group_reverse_stream.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------------------
// elem     | elem_valid / elem_stall    | value[31:0] signed, list_end
// res      | res_valid / res_stall      | value_out[31:0] signed, run_end,
//          |                            | list_done
// config   | group_size_we              | group_size[4:0]
//
// An element is taken and written into the current bank of a
// two-bank group store. Input stalls only while the bank being filled has not
// yet been read out in full by the back end, so one group can fill while the
// previous one drains.
// Results leave at one item per cycle once a burst starts, unless res_stall
// holds them; the first result of a burst passes the queue pop, the store
// read and the result buffer after the closing element is taken. Each burst
// starts with a queue pop ahead of its first read, which slows groups of one.
// Reset clears the fill count, the bank flags, the queues and sets the group
// size to one; the store itself needs no clearing.
// A stalled result leaves the four-entry result buffer holding, and reads stop
// once buffered plus in-flight results reach its depth.

module group_reverse_stream #(
	parameter int unsigned MAX_GROUP = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               group_size_we,
	input  logic [4:0]         group_size,
	input  logic               elem_valid,
	output logic               elem_stall,
	input  logic signed [31:0] value,
	input  logic               list_end,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] value_out,
	output logic               run_end,
	output logic               list_done
);

	import grs_pkg::*;

	// Address bits of one bank; a bank holds a whole group.
	localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

	logic         wr_en;
	logic [AW:0]  wr_addr;
	logic [31:0]  wr_data;
	logic         rd_en;
	logic [AW:0]  rd_addr;
	logic [31:0]  rd_data;

	logic         cmd_push;
	grs_cmd_t     cmd;
	logic         q_full;
	logic         q_pop;
	logic         q_empty;
	grs_cmd_t     q_head;
	grs_release_t rel;

	logic [31:0]  res_value;

	// Front end: takes elements, fills the bank and decides when a group closes
	// and in which order it has to leave.
	grs_front #(
		.MAX_GROUP (MAX_GROUP),
		.AW        (AW)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.group_size_we (group_size_we),
		.group_size    (group_size),
		.elem_valid    (elem_valid),
		.elem_stall    (elem_stall),
		.value         (value),
		.list_end      (list_end),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.cmd_push      (cmd_push),
		.cmd           (cmd),
		.q_full        (q_full),
		.rel           (rel)
	);

	// Closed groups wait here until the back end is free.
	grs_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	grs_store #(
		.AW (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Back end: walks one closed group forward or backward and buffers results.
	grs_back #(
		.AW (AW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.rel           (rel),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res_value     (res_value),
		.res_run_end   (run_end),
		.res_list_done (list_done)
	);

	assign value_out = signed'(res_value);

endmodule
